// ===== rtl/core/anp_pkg.sv =====
// anp_pkg: shared types and character constants for the ASCII number parser.
// Standalone package; used by anp_char_decode, anp_step and the core top level.
package anp_pkg;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [5:0] BASE_AUTO = 6'd0;
    localparam logic [5:0] BASE_MIN  = 6'd2;
    localparam logic [5:0] BASE_OCT  = 6'd8;
    localparam logic [5:0] BASE_DEC  = 6'd10;
    localparam logic [5:0] BASE_HEX  = 6'd16;
    localparam logic [5:0] BASE_MAX  = 6'd36;
    localparam logic [5:0] LETTER_OFS = 6'd10;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_LEAD      = 5'b00010,
        PH_ZERO_AUTO = 5'b00100,
        PH_ZERO_HEX  = 5'b01000,
        PH_DIGITS    = 5'b10000
    } anp_phase_t;

    // Character class of one input character
    typedef struct packed {
        logic       is_blank;
        logic       is_digit;   // 0-9, A-Z, a-z
        logic [5:0] digit;      // digit value, valid with is_digit
        logic       is_zero;
        logic       is_x;       // lowercase x only
    } anp_dec_t;

endpackage

// ===== rtl/core/anp_in_if.sv =====
// anp_in_if: character input channel (valid/ready plus one character beat).
// No dependencies.
interface anp_in_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [7:0] ch;

    modport source (output valid, output start_req, output ch, input ready);
    modport sink   (input valid, input start_req, input ch, output ready);
endinterface

// ===== rtl/core/anp_out_if.sv =====
// anp_out_if: conversion result channel (valid/ready plus one result beat).
// No dependencies; widths follow the core parameters.
interface anp_out_if #(
    parameter int VALUE_WIDTH    = 32,
    parameter int POSITION_WIDTH = 16
);
    logic                      valid;
    logic                      ready;
    logic [VALUE_WIDTH-1:0]    value;
    logic [POSITION_WIDTH-1:0] end_offset;
    logic                      any_digits;
    logic                      overflow;

    modport source (output valid, output value, output end_offset, output any_digits,
                    output overflow, input ready);
    modport sink   (input valid, input value, input end_offset, input any_digits,
                    input overflow, output ready);
endinterface

// ===== rtl/core/ascii_number_parser_core.sv =====
// ascii_number_parser_core: streaming ASCII to unsigned integer converter (strtoul).
// Depends on anp_pkg, anp_in_if, anp_out_if, anp_char_decode and anp_step.
//
//  channel   dir  beat contents                              handshake
//  chars     in   start_req, ch                              valid/ready
//  results   out  value, end_offset, any_digits, overflow    valid/ready
//  cfg       in   cfg_wdata (base_select)                    cfg_we, no wait
//
// One character per cycle, save while a stopping character waits on a held result:
// a beat is taken into the input register, then one pass of decode and multiply-add
// updates the conversion state. A stopping character's result is registered in the
// output register, which holds it until taken; characters that stop nothing keep
// flowing meanwhile, and only a second stopping character waits behind it.
// Reset clears the control state and the base register; no clearing pass.
module ascii_number_parser_core #(
    parameter int VALUE_WIDTH    = 32,
    parameter int POSITION_WIDTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    anp_in_if.sink          chars,
    anp_out_if.source       results,
    input  logic            cfg_we,
    input  logic [5:0]      cfg_wdata
);
    import anp_pkg::*;

    logic [5:0]                base_select_reg;

    logic                      s1_valid_reg;
    logic                      s1_start_reg;
    logic [7:0]                s1_ch_reg;

    anp_phase_t                phase_reg;
    logic [5:0]                base_reg;
    logic [VALUE_WIDTH-1:0]    acc_reg;
    logic                      seen_reg;
    logic [POSITION_WIDTH-1:0] pos_reg;
    logic                      wrap_reg;

    anp_phase_t                phase_next;
    logic [5:0]                base_next;
    logic [VALUE_WIDTH-1:0]    acc_next;
    logic                      seen_next;
    logic [POSITION_WIDTH-1:0] pos_next;
    logic                      wrap_next;

    logic                      out_valid_reg;
    logic [VALUE_WIDTH-1:0]    value_reg;
    logic [POSITION_WIDTH-1:0] end_offset_reg;
    logic                      any_digits_reg;
    logic                      overflow_reg;

    logic                      emit;
    logic [VALUE_WIDTH-1:0]    res_value;
    logic [POSITION_WIDTH-1:0] res_offset;
    logic                      res_any;
    logic                      res_ovf;

    anp_dec_t                  dec;
    logic                      out_free;
    logic                      s1_fire;

    anp_char_decode u_decode (
        .ch  (s1_ch_reg),
        .dec (dec)
    );

    anp_step #(
        .VALUE_WIDTH    (VALUE_WIDTH),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_step (
        .start_req   (s1_start_reg),
        .dec         (dec),
        .base_select (base_select_reg),
        .phase_cur   (phase_reg),
        .base_cur    (base_reg),
        .acc_cur     (acc_reg),
        .seen_cur    (seen_reg),
        .pos_cur     (pos_reg),
        .wrap_cur    (wrap_reg),
        .phase_nxt   (phase_next),
        .base_nxt    (base_next),
        .acc_nxt     (acc_next),
        .seen_nxt    (seen_next),
        .pos_nxt     (pos_next),
        .wrap_nxt    (wrap_next),
        .emit        (emit),
        .value       (res_value),
        .end_offset  (res_offset),
        .any_digits  (res_any),
        .overflow    (res_ovf)
    );

    assign out_free     = !out_valid_reg || results.ready;
    assign s1_fire      = s1_valid_reg && (!emit || out_free);
    assign chars.ready  = !s1_valid_reg || s1_fire;

    assign results.valid      = out_valid_reg;
    assign results.value      = value_reg;
    assign results.end_offset = end_offset_reg;
    assign results.any_digits = any_digits_reg;
    assign results.overflow   = overflow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_select_reg <= BASE_AUTO;
            s1_valid_reg    <= 1'b0;
            phase_reg       <= PH_IDLE;
            base_reg        <= '0;
            acc_reg         <= '0;
            seen_reg        <= 1'b0;
            pos_reg         <= '0;
            wrap_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                base_select_reg <= cfg_wdata;

            if (chars.ready)
                s1_valid_reg <= chars.valid;

            if (s1_fire)
            begin
                phase_reg <= phase_next;
                base_reg  <= base_next;
                acc_reg   <= acc_next;
                seen_reg  <= seen_next;
                pos_reg   <= pos_next;
                wrap_reg  <= wrap_next;
            end

            if (s1_fire && emit)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            s1_start_reg <= chars.start_req;
            s1_ch_reg    <= chars.ch;
        end
        if (s1_fire && emit)
        begin
            value_reg      <= res_value;
            end_offset_reg <= res_offset;
            any_digits_reg <= res_any;
            overflow_reg   <= res_ovf;
        end
    end

endmodule

// ===== rtl/core/anp_char_decode.sv =====
// anp_char_decode: classifies one character (whitespace, digit value, prefix chars).
// Depends on anp_pkg.
module anp_char_decode (
    input  logic [7:0]        ch,
    output anp_pkg::anp_dec_t dec
);
    import anp_pkg::*;

    always_comb
    begin
        dec          = '0;
        dec.is_blank = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
        dec.is_zero  = (ch == CH_ZERO);
        dec.is_x     = (ch == CH_LO_X);
        if ((ch >= CH_ZERO) && (ch <= CH_NINE))
        begin
            dec.is_digit = 1'b1;
            dec.digit    = 6'(ch - CH_ZERO);
        end
        else if ((ch >= CH_UP_A) && (ch <= CH_UP_Z))
        begin
            dec.is_digit = 1'b1;
            dec.digit    = 6'(ch - CH_UP_A) + LETTER_OFS;
        end
        else if ((ch >= CH_LO_A) && (ch <= CH_LO_Z))
        begin
            dec.is_digit = 1'b1;
            dec.digit    = 6'(ch - CH_LO_A) + LETTER_OFS;
        end
    end

endmodule

// ===== rtl/core/anp_step.sv =====
// anp_step: next-state and result logic for one character of the conversion.
// Depends on anp_pkg; fed by anp_char_decode.
module anp_step #(
    parameter int VALUE_WIDTH    = 32,
    parameter int POSITION_WIDTH = 16
) (
    input  logic                      start_req,
    input  anp_pkg::anp_dec_t         dec,
    input  logic [5:0]                base_select,
    input  anp_pkg::anp_phase_t       phase_cur,
    input  logic [5:0]                base_cur,
    input  logic [VALUE_WIDTH-1:0]    acc_cur,
    input  logic                      seen_cur,
    input  logic [POSITION_WIDTH-1:0] pos_cur,
    input  logic                      wrap_cur,
    output anp_pkg::anp_phase_t       phase_nxt,
    output logic [5:0]                base_nxt,
    output logic [VALUE_WIDTH-1:0]    acc_nxt,
    output logic                      seen_nxt,
    output logic [POSITION_WIDTH-1:0] pos_nxt,
    output logic                      wrap_nxt,
    output logic                      emit,
    output logic [VALUE_WIDTH-1:0]    value,
    output logic [POSITION_WIDTH-1:0] end_offset,
    output logic                      any_digits,
    output logic                      overflow
);
    import anp_pkg::*;

    localparam int PROD_WIDTH = VALUE_WIDTH + 6;

    anp_phase_t            ph_sel;
    logic                  take_en;
    logic                  take_ok;
    logic                  adv;
    logic [PROD_WIDTH-1:0] prod;

    always_comb
    begin
        ph_sel    = start_req ? PH_LEAD : phase_cur;
        phase_nxt = ph_sel;
        base_nxt  = start_req ? base_select : base_cur;
        acc_nxt   = start_req ? '0 : acc_cur;
        seen_nxt  = start_req ? 1'b0 : seen_cur;
        pos_nxt   = start_req ? '0 : pos_cur;
        wrap_nxt  = start_req ? 1'b0 : wrap_cur;
        take_en   = 1'b0;
        adv       = 1'b0;
        emit      = 1'b0;

        unique case (ph_sel) inside
            PH_LEAD:
            begin
                if (dec.is_blank)
                    adv = 1'b1;
                else if (dec.is_zero && (base_nxt == BASE_AUTO))
                begin
                    phase_nxt = PH_ZERO_AUTO;
                    adv       = 1'b1;
                end
                else
                begin
                    if (base_nxt == BASE_AUTO)
                        base_nxt = BASE_DEC;
                    if (dec.is_zero && (base_nxt == BASE_HEX))
                    begin
                        seen_nxt  = 1'b1;
                        phase_nxt = PH_ZERO_HEX;
                        adv       = 1'b1;
                    end
                    else
                    begin
                        phase_nxt = PH_DIGITS;
                        take_en   = 1'b1;
                    end
                end
            end
            PH_ZERO_AUTO, PH_ZERO_HEX:
            begin
                if (dec.is_x)
                begin
                    // prefix taken; the leading zero no longer counts as a digit
                    base_nxt  = BASE_HEX;
                    seen_nxt  = 1'b0;
                    phase_nxt = PH_DIGITS;
                    adv       = 1'b1;
                end
                else
                begin
                    if (ph_sel == PH_ZERO_AUTO)
                        base_nxt = BASE_OCT;
                    seen_nxt  = 1'b1;
                    phase_nxt = PH_DIGITS;
                    take_en   = 1'b1;
                end
            end
            PH_DIGITS:
                take_en = 1'b1;
            default:
                take_en = 1'b0;
        endcase

        take_ok = take_en && (base_nxt >= BASE_MIN) && (base_nxt <= BASE_MAX)
                  && dec.is_digit && (dec.digit < base_nxt);
        // acc*base+digit exceeds the value width exactly when the top bits are set
        prod = PROD_WIDTH'(acc_nxt) * PROD_WIDTH'(base_nxt) + PROD_WIDTH'(dec.digit);

        if (take_ok)
        begin
            wrap_nxt = wrap_nxt | (|prod[PROD_WIDTH-1:VALUE_WIDTH]);
            acc_nxt  = prod[VALUE_WIDTH-1:0];
            seen_nxt = 1'b1;
            adv      = 1'b1;
        end
        else if (take_en)
        begin
            emit      = 1'b1;
            phase_nxt = PH_IDLE;
        end

        if (adv && (pos_nxt != '1))
            pos_nxt = pos_nxt + 1'b1;

        value      = acc_nxt;
        end_offset = seen_nxt ? pos_nxt : '0;
        any_digits = seen_nxt;
        overflow   = wrap_nxt;
    end

endmodule

// ===== tb/ascii_number_parser_core_tb.sv =====
// ascii_number_parser_core_tb: self-checking bench for the streaming strtoul core.
// Depends on anp_pkg, anp_in_if, anp_out_if and the ascii_number_parser_core RTL.
// Directed table first, then random strings, checked by a local predictor or pinned rows.
`timescale 1ns / 1ps

module ascii_number_parser_core_tb;
    import anp_pkg::*;

    localparam int VW = 32;
    localparam int PW = 16;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [6:0] NOT_A_DIGIT = 7'd99;
    localparam logic [5:0] BASE_ONE    = 6'd1;
    localparam logic [5:0] BASE_OVER   = 6'd37;
    localparam logic [5:0] BASE_TOP    = 6'd63;

    localparam logic [7:0] BLANKS [6] = '{CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR};

    typedef struct packed {
        logic [VW-1:0] value;
        logic [PW-1:0] end_offset;
        logic          any_digits;
        logic          overflow;
    } conv_result_t;

    typedef struct {
        logic [5:0]   base;
        bit           fresh;     // first char carries start_req
        string        text;
        int           term;      // stopping char after text, -1 for none
        bit           pinned;    // expected result typed in below
        conv_result_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [5:0] cfg_wdata;

    anp_in_if                 chars_if ();
    anp_out_if #(VW, PW)      res_if ();

    ascii_number_parser_core #(
        .VALUE_WIDTH    (VW),
        .POSITION_WIDTH (PW)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars_if),
        .results   (res_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic [5:0]  cfg_base;
    anp_phase_t  ph;
    logic [5:0]  act_base;
    logic [VW-1:0] acc;
    logic        seen;
    logic [PW-1:0] pos;
    logic        wrap;

    conv_result_t pending_results [$];
    conv_result_t want;
    int          errors;
    int          fed_chars;
    int          src_idle_pct;
    int          snk_idle_pct;
    dir_row_t    dir_rows [9];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [6:0] digit_value(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return 7'(c - CH_ZERO);
        if (c >= CH_UP_A && c <= CH_UP_Z)
            return 7'(c - CH_UP_A) + 7'(LETTER_OFS);
        if (c >= CH_LO_A && c <= CH_LO_Z)
            return 7'(c - CH_LO_A) + 7'(LETTER_OFS);
        return NOT_A_DIGIT;
    endfunction

    function automatic void bump_pos();
        if (pos != '1)
            pos = pos + 1'b1;
    endfunction

    function automatic bit take_digit(logic [7:0] c);
        logic [6:0]  d;
        logic [63:0] limit;
        logic [63:0] sum;
        d = digit_value(c);
        if (act_base < BASE_MIN || act_base > BASE_MAX || d >= 7'(act_base))
            return 1'b0;
        limit = (64'hFFFF_FFFF - 64'(d)) / 64'(act_base);
        if (64'(acc) > limit)
            wrap = 1'b1;
        sum = 64'(acc) * 64'(act_base) + 64'(d);
        acc = sum[VW-1:0];
        seen = 1'b1;
        bump_pos();
        return 1'b1;
    endfunction

    task automatic step_char(input bit s, input logic [7:0] c,
                             output bit emitted, output conv_result_t res);
        emitted = 1'b0;
        res = '0;
        if (s)
        begin
            ph = PH_LEAD;
            act_base = cfg_base;
            acc = '0;
            seen = 1'b0;
            pos = '0;
            wrap = 1'b0;
        end
        case (ph)
            PH_LEAD:
            begin
                if (is_blank(c))
                    bump_pos();
                else if (c == CH_ZERO && act_base == BASE_AUTO)
                begin
                    ph = PH_ZERO_AUTO;
                    bump_pos();
                end
                else
                begin
                    if (act_base == BASE_AUTO)
                        act_base = BASE_DEC;
                    if (c == CH_ZERO && act_base == BASE_HEX)
                    begin
                        seen = 1'b1;
                        ph = PH_ZERO_HEX;
                        bump_pos();
                    end
                    else
                    begin
                        ph = PH_DIGITS;
                        emitted = !take_digit(c);
                    end
                end
            end
            PH_ZERO_AUTO, PH_ZERO_HEX:
            begin
                // only lowercase x forms the prefix; the zero is then not a digit
                if (c == CH_LO_X)
                begin
                    act_base = BASE_HEX;
                    seen = 1'b0;
                    ph = PH_DIGITS;
                    bump_pos();
                end
                else
                begin
                    if (ph == PH_ZERO_AUTO)
                        act_base = BASE_OCT;
                    seen = 1'b1;
                    ph = PH_DIGITS;
                    emitted = !take_digit(c);
                end
            end
            PH_DIGITS:
                emitted = !take_digit(c);
            default:
                ;
        endcase
        if (emitted)
        begin
            res.value = acc;
            res.end_offset = seen ? pos : '0;
            res.any_digits = seen;
            res.overflow = wrap;
            ph = PH_IDLE;
        end
    endtask

    task automatic drive_char(input bit s, input logic [7:0] c,
                              input bit pinned, input conv_result_t pinned_res);
        bit emitted;
        conv_result_t got;
        while ($urandom_range(99) < src_idle_pct)
        begin
            chars_if.valid <= 1'b0;
            @(posedge clk);
        end
        chars_if.valid <= 1'b1;
        chars_if.start_req <= s;
        chars_if.ch <= c;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        fed_chars++;
        step_char(s, c, emitted, got);
        if (emitted)
            pending_results.push_back(pinned ? pinned_res : got);
    endtask

    // base register changes only with the core drained
    task automatic write_base(input logic [5:0] b);
        chars_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= b;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_base = b;
    endtask

    function automatic logic [7:0] glyph(int d);
        if (d < 10)
            return CH_ZERO + 8'(d);
        return ($urandom_range(1) ? CH_UP_A : CH_LO_A) + 8'(d - 10);
    endfunction

    task automatic random_string();
        int kind;
        int n;
        int r;
        logic [5:0] eb;
        bit s_next;
        s_next = 1'b1;
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            // noise, with the odd restart in the middle
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                drive_char(i == 0 || $urandom_range(15) == 0, 8'($urandom_range(255)),
                           1'b0, '0);
            return;
        end
        n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
        for (int i = 0; i < n; i++)
        begin
            drive_char(s_next, BLANKS[$urandom_range(5)], 1'b0, '0);
            s_next = 1'b0;
        end
        eb = cfg_base;
        r = $urandom_range(2);
        if (cfg_base == BASE_AUTO || (cfg_base == BASE_HEX && r == 0))
        begin
            if (r == 0 || cfg_base == BASE_HEX)
            begin
                drive_char(s_next, CH_ZERO, 1'b0, '0);
                drive_char(1'b0, CH_LO_X, 1'b0, '0);
                eb = BASE_HEX;
            end
            else if (r == 1)
            begin
                drive_char(s_next, CH_ZERO, 1'b0, '0);
                eb = BASE_OCT;
            end
            else
                eb = BASE_DEC;
            if (r != 2 || cfg_base == BASE_HEX)
                s_next = 1'b0;
        end
        r = $urandom_range(99);
        n = (r < 10) ? 0 : (r < 85) ? $urandom_range(1, 6) : $urandom_range(7, 14);
        for (int i = 0; i < n; i++)
        begin
            if (eb < BASE_MIN || eb > BASE_MAX)
                drive_char(s_next, glyph($urandom_range(35)), 1'b0, '0);
            else
                drive_char(s_next, glyph($urandom_range(eb - 1)), 1'b0, '0);
            s_next = 1'b0;
        end
        if (kind >= 15)
            drive_char(s_next, $urandom_range(1) ? CH_NUL : 8'($urandom_range(255)),
                       1'b0, '0);
        if ($urandom_range(4) == 0)
        begin
            n = $urandom_range(1, 2);
            for (int i = 0; i < n; i++)
                drive_char(1'b0, 8'($urandom_range(255)), 1'b0, '0);
        end
    endtask

    // result side: random ready, one check per accepted beat
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no conversion pending");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_if.value !== want.value)
                begin
                    $error("value: expected %h, got %h", want.value, res_if.value);
                    errors++;
                end
                if (res_if.end_offset !== want.end_offset)
                begin
                    $error("end_offset: expected %0d, got %0d", want.end_offset,
                           res_if.end_offset);
                    errors++;
                end
                if (res_if.any_digits !== want.any_digits)
                begin
                    $error("any_digits: expected %b, got %b", want.any_digits,
                           res_if.any_digits);
                    errors++;
                end
                if (res_if.overflow !== want.overflow)
                begin
                    $error("overflow: expected %b, got %b", want.overflow, res_if.overflow);
                    errors++;
                end
            end
        end
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    initial
    begin
        int goal;
        int str_count;
        int pick;
        logic [5:0] nb;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        chars_if.valid = 1'b0;
        chars_if.start_req = 1'b0;
        chars_if.ch = '0;
        res_if.ready = 1'b0;
        errors = 0;
        fed_chars = 0;
        src_idle_pct = 6;
        snk_idle_pct = 88;
        cfg_base = BASE_AUTO;
        ph = PH_IDLE;
        act_base = '0;
        acc = '0;
        seen = 1'b0;
        pos = '0;
        wrap = 1'b0;

        dir_rows = '{
            '{BASE_AUTO, 1'b1, "\0110x1F", 255, 1'b0, '0},
            '{BASE_AUTO, 1'b1, "0X",       -1,  1'b1, '{32'h0, 16'd1, 1'b1, 1'b0}},
            '{BASE_AUTO, 1'b1, "0xg",      -1,  1'b1, '{32'h0, 16'd0, 1'b0, 1'b0}},
            '{BASE_AUTO, 1'b1, "07",       0,   1'b0, '0},
            '{BASE_AUTO, 1'b0, "5A",       -1,  1'b0, '0},
            '{BASE_MAX,  1'b1, "1z141z3",  0,   1'b1, '{32'hFFFF_FFFF, 16'd7, 1'b1, 1'b0}},
            '{BASE_MAX,  1'b1, "1z141z4",  0,   1'b1, '{32'h0, 16'd7, 1'b1, 1'b1}},
            '{BASE_ONE,  1'b1, " 5",       -1,  1'b1, '{32'h0, 16'd0, 1'b0, 1'b0}},
            '{BASE_TOP,  1'b1, "z",        -1,  1'b1, '{32'h0, 16'd0, 1'b0, 1'b0}}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_base(BASE_AUTO);
        for (int r = 0; r < 9; r++)
        begin
            if (dir_rows[r].base != cfg_base)
                write_base(dir_rows[r].base);
            for (int i = 0; i < dir_rows[r].text.len(); i++)
                drive_char(dir_rows[r].fresh && i == 0, dir_rows[r].text[i],
                           dir_rows[r].pinned, dir_rows[r].want);
            if (dir_rows[r].term >= 0)
                drive_char(1'b0, 8'(dir_rows[r].term), dir_rows[r].pinned, dir_rows[r].want);
        end

        for (int p = 0; p < 3; p++)
        begin
            src_idle_pct = (p == 0) ? 6 : (p == 1) ? 88 : 0;
            snk_idle_pct = (p == 0) ? 88 : (p == 1) ? 6 : 0;
            goal = fed_chars + 650;
            str_count = 0;
            while (fed_chars < goal)
            begin
                if (str_count % 18 == 0)
                begin
                    pick = $urandom_range(11);
                    case (pick)
                        0: nb = BASE_AUTO;
                        1: nb = BASE_MIN;
                        2: nb = BASE_OCT;
                        3: nb = BASE_DEC;
                        4: nb = BASE_HEX;
                        5: nb = BASE_MAX;
                        6: nb = BASE_ONE;
                        7: nb = BASE_OVER;
                        8: nb = BASE_TOP;
                        9: nb = BASE_AUTO;
                        default: nb = 6'($urandom_range(63));
                    endcase
                    write_base(nb);
                end
                random_string();
                str_count++;
            end
        end

        chars_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/anp_pkg.sv
rtl/core/anp_in_if.sv
rtl/core/anp_out_if.sv
rtl/core/anp_char_decode.sv
rtl/core/anp_step.sv
rtl/core/ascii_number_parser_core.sv
tb/ascii_number_parser_core_tb.sv
